// ----- rtl/clcu_pkg.sv -----
// ----------------------------------------------------------------------------
// clcu_pkg
// Types and constants shared by the circle lookahead unicycle command unit.
// ----------------------------------------------------------------------------
package clcu_pkg;

    typedef struct packed {
        logic signed [15:0] heading;
        logic [31:0]        time_ms;
    } in_t;

    typedef struct packed {
        logic [31:0]        stamp_ms;
        logic signed [31:0] linear_speed;
        logic signed [31:0] turn_rate;
        logic               saturated;
    } out_t;

    // Register indexes of the write port
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_PERIOD  = 2'd1;
    localparam logic [1:0] REG_FORWARD = 2'd2;
    localparam logic [1:0] REG_LATERAL = 2'd3;

    // CORDIC datapath widths: x/y in Q2.30 with headroom, z in turns
    localparam int XW = 34;
    localparam int ZW = 33;

    localparam logic signed [XW-1:0] CORDIC_START  = 34'sd652032874;
    localparam logic signed [30:0]   TURN_PER_RAD  = 31'sd683565276;
    localparam logic [36:0]          SPEED_CONST   = 37'd105414357067;

    // atan(2^-i) in turns (2^32 per revolution)
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2F9;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/clcu_div_cell.sv -----
// ----------------------------------------------------------------------------
// clcu_div_cell
// One restoring division step: retires one numerator bit per cycle.
// ----------------------------------------------------------------------------
module clcu_div_cell #(
    parameter int NW = 64,
    parameter int DW = 16,
    parameter int QW = 32,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [DW-1:0] divisor,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [QW-1:0] in_quo,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_num,
    output logic [QW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);
    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg, num_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [PW-1:0] pay_reg;
    logic [DW:0]   trial, diff;
    logic          ge;

    always_comb
    begin
        trial    = {in_rem, in_num[NW-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        num_next = {in_num[NW-2:0], 1'b0};
        quo_next = {in_quo[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        pay_reg <= in_pay;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_pay   = pay_reg;
endmodule

// ----- rtl/clcu_div_chain.sv -----
// ----------------------------------------------------------------------------
// clcu_div_chain
// Row of division cells: unsigned pipelined divider, one item per cycle.
// ----------------------------------------------------------------------------
module clcu_div_chain #(
    parameter int NW = 64,
    parameter int DW = 16,
    parameter int QW = 32,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [DW-1:0] divisor,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);
    logic          valid_s [NW+1];
    logic [DW-1:0] rem_s   [NW+1];
    logic [NW-1:0] num_s   [NW+1];
    logic [QW-1:0] quo_s   [NW+1];
    logic [PW-1:0] pay_s   [NW+1];

    assign valid_s[0] = in_valid;
    assign rem_s[0]   = '0;
    assign num_s[0]   = in_num;
    assign quo_s[0]   = '0;
    assign pay_s[0]   = in_pay;

    for (genvar k = 0; k < NW; k++)
    begin : g_cell
        clcu_div_cell #(
            .NW(NW), .DW(DW), .QW(QW), .PW(PW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .divisor  (divisor),
            .in_valid (valid_s[k]),
            .in_rem   (rem_s[k]),
            .in_num   (num_s[k]),
            .in_quo   (quo_s[k]),
            .in_pay   (pay_s[k]),
            .out_valid(valid_s[k+1]),
            .out_rem  (rem_s[k+1]),
            .out_num  (num_s[k+1]),
            .out_quo  (quo_s[k+1]),
            .out_pay  (pay_s[k+1])
        );
    end

    assign out_valid = valid_s[NW];
    assign out_quo   = quo_s[NW];
    assign out_pay   = pay_s[NW];
endmodule

// ----- rtl/clcu_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// clcu_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module clcu_cordic_cell #(
    parameter int STEP = 0,
    parameter int PW   = 1
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic signed [clcu_pkg::XW-1:0] in_x,
    input  logic signed [clcu_pkg::XW-1:0] in_y,
    input  logic signed [clcu_pkg::ZW-1:0] in_z,
    input  logic [PW-1:0] in_pay,
    output logic out_valid,
    output logic signed [clcu_pkg::XW-1:0] out_x,
    output logic signed [clcu_pkg::XW-1:0] out_y,
    output logic signed [clcu_pkg::ZW-1:0] out_z,
    output logic [PW-1:0] out_pay
);
    import clcu_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = $signed({1'b0, atan_turn(STEP)});

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [PW-1:0]        pay_reg;

    always_comb
    begin
        xs = in_x >>> STEP;
        ys = in_y >>> STEP;
        if (!in_z[ZW-1])
        begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN;
        end
        else
        begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        pay_reg <= in_pay;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_pay   = pay_reg;
endmodule

// ----- rtl/circle_lookahead_unicycle_command_unit.sv -----
// ----------------------------------------------------------------------------
// circle_lookahead_unicycle_command_unit
// Offset-point unicycle commands for tracking a point on a circle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd (heading, time_ms) and pulse start; an item is
//   taken on every edge where start is high and busy is low. busy stays low,
//   so an item may enter in every cycle.
//   Result channel: done is high for one cycle with result (stamp, linear
//   speed, turn rate, saturation flag). Results leave in command order and
//   the receiver cannot stall them.
//   Throughput: one item per cycle; every stage hands its item on each
//   cycle: 64 phase-division cells, CORDIC_STEPS rotation cells, a row
//   of 60 cells for each division by the forward offset, and the unfold,
//   speed-product, combine and lateral stages and the output register.
//   Configuration: wr_en/wr_index/wr_data write one register per cycle.
//   The reference speed is divided out of the radius and period by a free
//   running 53-cell divider and a register; after a write it settles before
//   any item that follows the write reaches the point where it is used.
//   Reset: clears the pipeline valid bits and loads the default radius,
//   period and offsets.
// ----------------------------------------------------------------------------
module circle_lookahead_unicycle_command_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  clcu_pkg::in_t  cmd,
    output logic           done,
    output clcu_pkg::out_t result,
    input  logic           wr_en,
    input  logic [1:0]     wr_index,
    input  logic [15:0]    wr_data
);
    import clcu_pkg::*;

    localparam logic signed [61:0] CLIP_MAX = 62'sd2147483647;
    localparam logic signed [61:0] CLIP_MIN = -62'sd2147483648;
    localparam logic signed [31:0] QTR_TURN = 32'sd1073741824;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        radius_reg;
    logic [15:0]        period_reg;
    logic [14:0]        fwd_reg;
    logic signed [15:0] lat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            period_reg <= 16'd10000;
            fwd_reg    <= 15'd128;
            lat_reg    <= 16'sd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_RADIUS:  radius_reg <= wr_data;
                REG_PERIOD:  period_reg <= wr_data;
                REG_FORWARD: fwd_reg    <= wr_data[14:0];
                REG_LATERAL: lat_reg    <= $signed(wr_data);
                default: ;
            endcase
        end
    end

    // Zero period and zero offset act as one
    logic [15:0] period_eff;
    logic [14:0] fwd_eff;
    assign period_eff = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign fwd_eff    = (fwd_reg == 15'd0) ? 15'd1 : fwd_reg;

    // Every cycle takes an item
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Reference speed: (R * 2*pi * 1000 * 2^24) / period, then round off
    // 16 bits to get Q16.16. Runs off the registers alone, independent
    // of items.
    // ------------------------------------------------------------------
    logic [52:0] sp_num, sp_quo;
    logic        sp_valid;
    logic [53:0] sp_round;
    logic [37:0] speed_reg;

    assign sp_num = 53'(radius_reg) * SPEED_CONST;

    clcu_div_chain #(
        .NW(53), .DW(16), .QW(53), .PW(1)
    ) u_speed_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .divisor  (period_eff),
        .in_valid (1'b1),
        .in_num   (sp_num),
        .in_pay   (1'b0),
        .out_valid(sp_valid),
        .out_quo  (sp_quo),
        .out_pay  ()
    );

    assign sp_round = {1'b0, sp_quo} + 54'h8000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
        end
        else
        begin
            // hold zero until the divider has filled once
            speed_reg <= sp_valid ? sp_round[53:16] : '0;
        end
    end

    // ------------------------------------------------------------------
    // Heading to turns and reference phase.
    // Dividing time*2^32 by the period leaves the phase in the low
    // 32 quotient bits; the upper bits are whole revolutions.
    // ------------------------------------------------------------------
    logic signed [46:0] head_prod;
    logic [31:0]        head_turns, phase, ph_head, ph_stamp;
    logic               ph_valid;
    logic [63:0]        ph_pay;

    assign head_prod  = $signed(cmd.heading) * TURN_PER_RAD;
    assign head_turns = head_prod[44:13];

    clcu_div_chain #(
        .NW(64), .DW(16), .QW(32), .PW(64)
    ) u_phase_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .divisor  (period_eff),
        .in_valid (start),
        .in_num   ({cmd.time_ms, 32'b0}),
        .in_pay   ({cmd.time_ms, head_turns}),
        .out_valid(ph_valid),
        .out_quo  (phase),
        .out_pay  (ph_pay)
    );

    assign ph_stamp = ph_pay[63:32];
    assign ph_head  = ph_pay[31:0];

    // Angle difference, folded into the right half plane
    logic signed [31:0] z_diff, z_fold;
    logic               flip;

    always_comb
    begin
        z_diff = $signed(ph_head - phase);
        flip   = (z_diff > QTR_TURN) || (z_diff < -QTR_TURN);
        z_fold = flip ? $signed({~z_diff[31], z_diff[30:0]}) : z_diff;
    end

    // ------------------------------------------------------------------
    // CORDIC row
    // ------------------------------------------------------------------
    logic                 cv [CORDIC_STEPS+1];
    logic signed [XW-1:0] cx [CORDIC_STEPS+1];
    logic signed [XW-1:0] cy [CORDIC_STEPS+1];
    logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
    logic [32:0]          cp [CORDIC_STEPS+1];

    assign cv[0] = ph_valid;
    assign cx[0] = CORDIC_START;
    assign cy[0] = '0;
    assign cz[0] = ZW'(z_fold);
    assign cp[0] = {ph_stamp, flip};

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        clcu_cordic_cell #(
            .STEP(i), .PW(33)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (cv[i]),
            .in_x     (cx[i]),
            .in_y     (cy[i]),
            .in_z     (cz[i]),
            .in_pay   (cp[i]),
            .out_valid(cv[i+1]),
            .out_x    (cx[i+1]),
            .out_y    (cy[i+1]),
            .out_z    (cz[i+1]),
            .out_pay  (cp[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Undo the fold, drop to Q4.24
    // ------------------------------------------------------------------
    logic signed [XW-1:0] sn_full, cs_full;
    logic                 p_valid_reg;
    logic signed [27:0]   sn6_reg, cs6_reg;
    logic [31:0]          p_stamp_reg;

    assign sn_full = cp[CORDIC_STEPS][0] ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
    assign cs_full = cp[CORDIC_STEPS][0] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];

    // ------------------------------------------------------------------
    // Stage A: split speed products. Stage B: combine, scale to Q16.16.
    // Stage C: lateral product and turn numerator.
    // ------------------------------------------------------------------
    logic               a_valid_reg, b_valid_reg, c_valid_reg;
    logic [31:0]        a_stamp_reg, b_stamp_reg, c_stamp_reg;
    logic signed [47:0] ash_reg, asl_reg, ach_reg, acl_reg;
    logic signed [67:0] u_sum, w_sum;
    logic signed [43:0] bu_reg, bw_reg, cu_reg;
    logic signed [59:0] cyw_reg;
    logic signed [51:0] cw8_reg;

    assign u_sum = (68'(ash_reg) <<< 19) + 68'(asl_reg);
    assign w_sum = (68'(ach_reg) <<< 19) + 68'(acl_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cv[CORDIC_STEPS];
            a_valid_reg <= p_valid_reg;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sn6_reg     <= sn_full[XW-1:6];
        cs6_reg     <= cs_full[XW-1:6];
        p_stamp_reg <= cp[CORDIC_STEPS][32:1];

        ash_reg     <= $signed({1'b0, speed_reg[37:19]}) * sn6_reg;
        asl_reg     <= $signed({1'b0, speed_reg[18:0]}) * sn6_reg;
        ach_reg     <= $signed({1'b0, speed_reg[37:19]}) * cs6_reg;
        acl_reg     <= $signed({1'b0, speed_reg[18:0]}) * cs6_reg;
        a_stamp_reg <= p_stamp_reg;

        bu_reg      <= u_sum[67:24];
        bw_reg      <= w_sum[67:24];
        b_stamp_reg <= a_stamp_reg;

        cyw_reg     <= lat_reg * bw_reg;
        cw8_reg     <= {bw_reg, 8'b0};
        cu_reg      <= bu_reg;
        c_stamp_reg <= b_stamp_reg;
    end

    // ------------------------------------------------------------------
    // Divisions by the forward offset, on magnitudes; sign restored after
    // so the quotient truncates toward zero.
    // ------------------------------------------------------------------
    logic        s_yw, s_w;
    logic [59:0] mag_yw, mag_w8, q_yw, q_w8;
    logic        dv1_valid, dv2_valid;
    logic [76:0] dv1_pay;
    logic        dv2_pay;

    assign s_yw   = cyw_reg[59];
    assign s_w    = cw8_reg[51];
    assign mag_yw = s_yw ? 60'(-cyw_reg) : 60'(cyw_reg);
    assign mag_w8 = s_w ? 60'(-60'(cw8_reg)) : 60'(cw8_reg);

    clcu_div_chain #(
        .NW(60), .DW(15), .QW(60), .PW(77)
    ) u_lat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .divisor  (fwd_eff),
        .in_valid (c_valid_reg),
        .in_num   (mag_yw),
        .in_pay   ({c_stamp_reg, cu_reg, s_yw}),
        .out_valid(dv1_valid),
        .out_quo  (q_yw),
        .out_pay  (dv1_pay)
    );

    clcu_div_chain #(
        .NW(60), .DW(15), .QW(60), .PW(1)
    ) u_turn_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .divisor  (fwd_eff),
        .in_valid (c_valid_reg),
        .in_num   (mag_w8),
        .in_pay   (s_w),
        .out_valid(dv2_valid),
        .out_quo  (q_w8),
        .out_pay  (dv2_pay)
    );

    // ------------------------------------------------------------------
    // Final sum, clip and output register
    // ------------------------------------------------------------------
    logic signed [43:0] e_u;
    logic signed [60:0] q1, q2;
    logic signed [61:0] v_sum, om_sum;
    logic               sat_v, sat_om;
    logic [31:0]        v_clip, om_clip;
    logic               done_reg;
    out_t               result_reg;

    always_comb
    begin
        e_u     = $signed(dv1_pay[44:1]);
        q1      = dv1_pay[0] ? -$signed({1'b0, q_yw}) : $signed({1'b0, q_yw});
        q2      = dv2_pay ? -$signed({1'b0, q_w8}) : $signed({1'b0, q_w8});
        v_sum   = 62'(e_u) + 62'(q1);
        om_sum  = 62'(q2);
        sat_v   = (v_sum > CLIP_MAX) || (v_sum < CLIP_MIN);
        sat_om  = (om_sum > CLIP_MAX) || (om_sum < CLIP_MIN);
        if (v_sum > CLIP_MAX)
        begin
            v_clip = 32'h7FFFFFFF;
        end
        else if (v_sum < CLIP_MIN)
        begin
            v_clip = 32'h80000000;
        end
        else
        begin
            v_clip = v_sum[31:0];
        end
        if (om_sum > CLIP_MAX)
        begin
            om_clip = 32'h7FFFFFFF;
        end
        else if (om_sum < CLIP_MIN)
        begin
            om_clip = 32'h80000000;
        end
        else
        begin
            om_clip = om_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv1_valid & dv2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.stamp_ms     <= dv1_pay[76:45];
        result_reg.linear_speed <= $signed(v_clip);
        result_reg.turn_rate    <= $signed(om_clip);
        result_reg.saturated    <= sat_v | sat_om;
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circle lookahead unicycle command unit: drives
// heading/time commands under several register settings and sender idling
// patterns, predicts each command in fixed point and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import clcu_pkg::*;

    localparam int  PIPE_DEPTH    = 129 + 16;
    localparam int  QUIET_CYCLES  = PIPE_DEPTH + 20;
    localparam int  STALL_LIMIT   = 4000;
    localparam longint HALF_REV   = 64'sd2147483648;
    localparam longint RAD_TO_REV = 64'sd683565276;
    localparam longint GAIN_START = 64'sd652032874;
    localparam longint SPEED_K    = 64'sd105414357067;

    // atan(2^-i) expressed in turns (2^32 per revolution)
    localparam longint ATAN_REV [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         cmd;
    logic        done;
    out_t        result;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [15:0] wr_data;

    // Shadow copy of the unit's registers
    logic [15:0] radius_q;
    logic [15:0] period_q;
    logic [14:0] forward_q;
    logic [15:0] lateral_q;

    out_t   pending_cmds[$];
    int     mismatch_cnt;
    int     sent_cnt;
    int     checked_cnt;
    int     sat_cnt;
    int     stall_cnt;
    int     idle_pct;

    circle_lookahead_unicycle_command_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Compute the command pair that one heading/time item should produce
    function automatic out_t predict_command(in_t c);
        out_t   r;
        longint per, fwd, lat, head, ph, d, z, x, y, nx, s32, speed, u, w, v, om;
        bit     flip;
        bit     sat;
        per  = (period_q == 0) ? 1 : longint'(period_q);
        fwd  = (forward_q == 0) ? 1 : longint'(forward_q);
        lat  = longint'($signed(lateral_q));
        head = (longint'(c.heading) * RAD_TO_REV) >>> 13;
        ph   = (((longint'({32'b0, c.time_ms})) % per) << 32) / per;
        d    = (head - ph) & 64'hFFFF_FFFF;
        z    = (d >= HALF_REV) ? d - 2 * HALF_REV : d;
        // fold into +-quarter turn, rotate, then flip back
        flip = 1'b0;
        if (z > HALF_REV / 2)
        begin
            z = z - HALF_REV;
            flip = 1'b1;
        end
        else if (z < -(HALF_REV / 2))
        begin
            z = z + HALF_REV;
            flip = 1'b1;
        end
        x = GAIN_START;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_REV[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_REV[i];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s32   = (longint'(radius_q) * SPEED_K) / per;
        speed = (s32 + 32768) >>> 16;
        u     = (speed * (y >>> 6)) >>> 24;
        w     = (speed * (x >>> 6)) >>> 24;
        v     = u + (lat * w) / fwd;
        om    = (w * 256) / fwd;
        sat   = 1'b0;
        if (v > 64'sd2147483647)       begin v = 64'sd2147483647;   sat = 1'b1; end
        else if (v < -64'sd2147483648) begin v = -64'sd2147483648;  sat = 1'b1; end
        if (om > 64'sd2147483647)       begin om = 64'sd2147483647;  sat = 1'b1; end
        else if (om < -64'sd2147483648) begin om = -64'sd2147483648; sat = 1'b1; end
        r.stamp_ms     = c.time_ms;
        r.linear_speed = v[31:0];
        r.turn_rate    = om[31:0];
        r.saturated    = sat;
        return r;
    endfunction

    // Track writes, predict accepted items, check results, watch for hangs
    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_r;
        if (!rst_n)
        begin
            radius_q  <= 16'd256;
            period_q  <= 16'd10000;
            forward_q <= 15'd128;
            lateral_q <= 16'd0;
            stall_cnt <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_RADIUS:  radius_q  <= wr_data;
                    REG_PERIOD:  period_q  <= wr_data;
                    REG_FORWARD: forward_q <= wr_data[14:0];
                    REG_LATERAL: lateral_q <= wr_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                pending_cmds.push_back(predict_command(cmd));
                sent_cnt++;
            end
            if (done)
            begin
                checked_cnt++;
                if (pending_cmds.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: unexpected result stamp=%0d", result.stamp_ms);
                end
                else
                begin
                    exp_r = pending_cmds.pop_front();
                    if (exp_r.saturated)
                        sat_cnt++;
                    if (result.stamp_ms !== exp_r.stamp_ms
                        || result.linear_speed !== exp_r.linear_speed
                        || result.turn_rate !== exp_r.turn_rate
                        || result.saturated !== exp_r.saturated)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("ERROR: stamp exp %0d got %0d, v exp %0d got %0d, %s%0d %s%0d, %s%0b %s%0b",
                                exp_r.stamp_ms, result.stamp_ms,
                                exp_r.linear_speed, result.linear_speed,
                                "w exp ", exp_r.turn_rate, "got ", result.turn_rate,
                                "sat exp ", exp_r.saturated, "got ", result.saturated);
                    end
                end
            end
            // count cycles with nothing moving on either side
            if ((start && !busy) || done)
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    always @(posedge clk)
    begin
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Send one item; hold start through back pressure, idle first at random
    task automatic send_cmd(logic signed [15:0] hd, logic [31:0] t);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            cmd   = in_t'($urandom);
            @(negedge clk);
        end
        start       = 1'b1;
        cmd.heading = hd;
        cmd.time_ms = t;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start, drain every pending result, then let the pipe go quiet
    task automatic drain_pipe();
        @(negedge clk);
        start = 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = val;
        @(negedge clk);
        wr_en    = 1'b0;
    endtask

    task automatic set_regs(logic [15:0] rad, logic [15:0] per, logic [15:0] fwd,
                            logic [15:0] lat);
        drain_pipe();
        write_reg(REG_RADIUS, rad);
        write_reg(REG_PERIOD, per);
        write_reg(REG_FORWARD, fwd);
        write_reg(REG_LATERAL, lat);
    endtask

    // Pick a time: fully random, or close to a revolution boundary
    function automatic logic [31:0] pick_time();
        logic [31:0] per;
        per = (period_q == 0) ? 32'd1 : {16'b0, period_q};
        case ($urandom_range(3))
            0, 1:    return $urandom;
            2:       return per * $urandom_range(65535) + $urandom_range(3);
            default: return per * $urandom_range(65535) - $urandom_range(1, 3);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_heading();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(51472) - 25736);
    endfunction

    // Heading and time extremes under the reset registers
    task automatic test_reset_defaults();
        idle_pct = 0;
        send_cmd(16'sd0, 32'd0);
        send_cmd(16'sd25736, 32'd0);
        send_cmd(-16'sd25736, 32'd0);
        send_cmd(16'sd12868, 32'd2500);
        send_cmd(-16'sd12868, 32'd7500);
        send_cmd(16'sh7FFF, 32'hFFFF_FFFF);
        send_cmd(16'sh8000, 32'd9999);
        send_cmd(16'sd1, 32'd10000);
        send_cmd(-16'sd1, 32'd5000);
    endtask

    // Register extremes: saturation, zero period, zero forward offset
    task automatic test_register_extremes();
        set_regs(16'hFFFF, 16'd1, 16'd1, 16'h8000);
        send_cmd(16'sd0, 32'd0);
        send_cmd(16'sd12868, 32'd17);
        send_cmd(-16'sd25736, 32'hFFFF_FFFF);
        set_regs(16'hFFFF, 16'd0, 16'd0, 16'h7FFF);
        send_cmd(16'sd6434, 32'd123456);
        send_cmd(16'sh8000, 32'hFFFF_FFFF);
        set_regs(16'd0, 16'hFFFF, 16'h7FFF, 16'h0000);
        send_cmd(16'sd100, 32'd65534);
        send_cmd(16'sh7FFF, 32'd65535);
        set_regs(16'h1234, 16'hFFFF, 16'h7FFF, 16'h8000);
        send_cmd(-16'sd3000, 32'd32768);
        send_cmd(16'sd25736, 32'hFFFF_FFFF);
    endtask

    // Random items under random and extreme settings with changing idling
    task automatic test_random_traffic();
        int pcts[3] = '{0, 57, 10};
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 3)
                0: set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                1: set_regs(16'($urandom_range(2048)), 16'($urandom_range(1, 20000)),
                            16'($urandom_range(1, 1024)),
                            16'($urandom_range(4096) - 2048));
                default: set_regs(16'($urandom), 16'($urandom_range(2)),
                                  16'($urandom_range(2)), 16'($urandom));
            endcase
            idle_pct = pcts[ph % 3];
            repeat (150)
                send_cmd(pick_heading(), pick_time());
        end
    endtask

    initial
    begin
        start        = 1'b0;
        cmd          = '0;
        wr_en        = 1'b0;
        wr_index     = REG_RADIUS;
        wr_data      = '0;
        idle_pct     = 0;
        mismatch_cnt = 0;
        sent_cnt     = 0;
        checked_cnt  = 0;
        sat_cnt      = 0;
        rst_n        = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();
        drain_pipe();

        $display("Sent %0d commands, checked %0d results (%0d saturated) over 14 settings.",
                 sent_cnt, checked_cnt, sat_cnt);
        if (mismatch_cnt == 0 && pending_cmds.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt,
                     pending_cmds.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
